### rtl/dhlt_pkg.sv
`timescale 1ns / 1ps

package dhlt_pkg;

    localparam int ANGLE_BITS_DEF  = 16;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int TRIG_STAGES_DEF = 16;

    // Q2.30 rotation values carry headroom for the gain overshoot
    localparam int XY_W   = 34;
    localparam int Z_W    = 33;
    localparam int TRIG_W = 16;
    localparam int ATAN_N = 24;

    localparam logic signed [XY_W-1:0] X_INIT = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q14 = 16'sd16384;

    // arctan(2^-i) as a fraction of a full turn, 2^32 per turn
    localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        t_quad                  quad;
    } t_lane;

    // Fold a 32-bit binary angle to the nearest quadrant and seed the rotation
    function automatic t_lane start_lane(input logic [31:0] z32);
        logic [31:0] zq;
        logic [31:0] zr;
        t_lane       l;
        zq     = z32 + 32'h2000_0000;
        zr     = z32 - {zq[31:30], 30'd0};
        l.x    = X_INIT;
        l.y    = '0;
        l.z    = Z_W'($signed(zr));
        l.quad = t_quad'(zq[31:30]);
        return l;
    endfunction

endpackage

### rtl/dhlt_cell.sv
`timescale 1ns / 1ps

module dhlt_cell #(
    parameter int STAGE       = 0,
    parameter int LENGTH_BITS = dhlt_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  dhlt_pkg::t_lane        i_alpha,
    input  dhlt_pkg::t_lane        i_theta,
    input  logic [LENGTH_BITS-1:0] i_len_a,
    input  logic [LENGTH_BITS-1:0] i_len_d,
    output logic                   o_valid,
    output dhlt_pkg::t_lane        o_alpha,
    output dhlt_pkg::t_lane        o_theta,
    output logic [LENGTH_BITS-1:0] o_len_a,
    output logic [LENGTH_BITS-1:0] o_len_d
);

    function automatic dhlt_pkg::t_lane rot(input dhlt_pkg::t_lane l);
        logic signed [dhlt_pkg::XY_W-1:0] dx;
        logic signed [dhlt_pkg::XY_W-1:0] dy;
        logic signed [dhlt_pkg::Z_W-1:0]  da;
        dhlt_pkg::t_lane                  o;
        dx = $signed(l.y) >>> STAGE;
        dy = $signed(l.x) >>> STAGE;
        da = dhlt_pkg::Z_W'(dhlt_pkg::ATAN_TURN[STAGE]);
        o  = l;
        // residual of zero counts as positive
        if (!l.z[dhlt_pkg::Z_W-1]) begin
            o.x = l.x - dx;
            o.y = l.y + dy;
            o.z = l.z - da;
        end else begin
            o.x = l.x + dx;
            o.y = l.y - dy;
            o.z = l.z + da;
        end
        return o;
    endfunction

    logic                   r_valid;
    dhlt_pkg::t_lane        r_alpha;
    dhlt_pkg::t_lane        r_theta;
    logic [LENGTH_BITS-1:0] r_len_a;
    logic [LENGTH_BITS-1:0] r_len_d;
    dhlt_pkg::t_lane        n_alpha;
    dhlt_pkg::t_lane        n_theta;

    always_comb begin
        n_alpha = rot(i_alpha);
        n_theta = rot(i_theta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_alpha <= n_alpha;
            r_theta <= n_theta;
            r_len_a <= i_len_a;
            r_len_d <= i_len_d;
        end
    end

    assign o_valid = r_valid;
    assign o_alpha = r_alpha;
    assign o_theta = r_theta;
    assign o_len_a = r_len_a;
    assign o_len_d = r_len_d;

endmodule

### rtl/dhlt_fin.sv
`timescale 1ns / 1ps

module dhlt_fin #(
    parameter int LENGTH_BITS = dhlt_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  dhlt_pkg::t_lane        i_alpha,
    input  dhlt_pkg::t_lane        i_theta,
    input  logic [LENGTH_BITS-1:0] i_len_a,
    input  logic [LENGTH_BITS-1:0] i_len_d,
    output logic                   o_valid,
    output logic [15:0]            o_m00,
    output logic [15:0]            o_m01,
    output logic [LENGTH_BITS-1:0] o_m03,
    output logic [15:0]            o_m10,
    output logic [15:0]            o_m11,
    output logic [15:0]            o_m12,
    output logic [LENGTH_BITS-1:0] o_m13,
    output logic [15:0]            o_m20,
    output logic [15:0]            o_m21,
    output logic [15:0]            o_m22,
    output logic [LENGTH_BITS-1:0] o_m23
);

    localparam int TW = dhlt_pkg::TRIG_W;
    localparam int RW = dhlt_pkg::XY_W - 16;
    localparam int PW = LENGTH_BITS + 16;

    // Round Q2.30 to Q2.14 and clamp to plus or minus one
    function automatic logic signed [TW-1:0] round_q14(input logic signed [dhlt_pkg::XY_W-1:0] x);
        logic signed [dhlt_pkg::XY_W-1:0] xr;
        logic signed [RW-1:0]             t;
        xr = x + dhlt_pkg::XY_W'(32768);
        t  = xr[dhlt_pkg::XY_W-1:16];
        if (t > RW'(16384)) begin
            return dhlt_pkg::ONE_Q14;
        end else if (t < -RW'(16384)) begin
            return -dhlt_pkg::ONE_Q14;
        end else begin
            return t[TW-1:0];
        end
    endfunction

    // Undo the quadrant fold: returns {sin, cos}
    function automatic logic [2*TW-1:0] unfold(input dhlt_pkg::t_quad q,
                                               input logic signed [TW-1:0] c,
                                               input logic signed [TW-1:0] s);
        logic [2*TW-1:0] r;
        case (q)
            dhlt_pkg::QUAD_0: r = {s, c};
            dhlt_pkg::QUAD_1: r = {c, -s};
            dhlt_pkg::QUAD_2: r = {-s, -c};
            dhlt_pkg::QUAD_3: r = {-c, s};
            default:          r = {s, c};
        endcase
        return r;
    endfunction

    function automatic logic [TW-1:0] round_trig(input logic signed [2*TW-1:0] p);
        logic signed [2*TW-1:0] pr;
        pr = p + 32'sd8192;
        return pr[TW+13:14];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] round_len(input logic signed [PW-1:0] p);
        logic signed [PW-1:0]          pr;
        logic signed [LENGTH_BITS+1:0] t;
        logic signed [LENGTH_BITS+1:0] tmax;
        logic signed [LENGTH_BITS+1:0] tmin;
        pr   = p + PW'(8192);
        t    = pr[PW-1:14];
        tmax = {3'b000, {(LENGTH_BITS-1){1'b1}}};
        tmin = {3'b111, {(LENGTH_BITS-1){1'b0}}};
        if (t > tmax) begin
            return tmax[LENGTH_BITS-1:0];
        end else if (t < tmin) begin
            return tmin[LENGTH_BITS-1:0];
        end else begin
            return t[LENGTH_BITS-1:0];
        end
    endfunction

    // Stage 1: rounding and quadrant
    logic                          r1_valid;
    logic signed [TW-1:0]          r1_ct, r1_st, r1_ca, r1_sa;
    logic [LENGTH_BITS-1:0]        r1_a;
    logic signed [LENGTH_BITS-1:0] r1_d;
    logic [2*TW-1:0]               n1_alpha;
    logic [2*TW-1:0]               n1_theta;

    // Stage 2: products
    logic                          r2_valid;
    logic signed [2*TW-1:0]        r2_st_ca, r2_ct_ca, r2_st_sa, r2_ct_sa;
    logic signed [PW-1:0]          r2_nsa_d, r2_ca_d;
    logic [TW-1:0]                 r2_ct, r2_nst, r2_nsa, r2_ca;
    logic [LENGTH_BITS-1:0]        r2_a;

    // Stage 3: output register
    logic                          r3_valid;

    always_comb begin
        n1_alpha = unfold(i_alpha.quad, round_q14(i_alpha.x), round_q14(i_alpha.y));
        n1_theta = unfold(i_theta.quad, round_q14(i_theta.x), round_q14(i_theta.y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ca <= n1_alpha[TW-1:0];
            r1_sa <= n1_alpha[2*TW-1:TW];
            r1_ct <= n1_theta[TW-1:0];
            r1_st <= n1_theta[2*TW-1:TW];
            r1_a  <= i_len_a;
            r1_d  <= i_len_d;

            r2_st_ca <= r1_st * r1_ca;
            r2_ct_ca <= r1_ct * r1_ca;
            r2_st_sa <= r1_st * r1_sa;
            r2_ct_sa <= r1_ct * r1_sa;
            r2_nsa_d <= (-r1_sa) * r1_d;
            r2_ca_d  <= r1_ca * r1_d;
            r2_ct    <= r1_ct;
            r2_nst   <= -r1_st;
            r2_nsa   <= -r1_sa;
            r2_ca    <= r1_ca;
            r2_a     <= r1_a;

            o_m00 <= r2_ct;
            o_m01 <= r2_nst;
            o_m03 <= r2_a;
            o_m10 <= round_trig(r2_st_ca);
            o_m11 <= round_trig(r2_ct_ca);
            o_m12 <= r2_nsa;
            o_m13 <= round_len(r2_nsa_d);
            o_m20 <= round_trig(r2_st_sa);
            o_m21 <= round_trig(r2_ct_sa);
            o_m22 <= r2_ca;
            o_m23 <= round_len(r2_ca_d);
        end
    end

    assign o_valid = r3_valid;

endmodule

### rtl/dh_link_transform.sv
`timescale 1ns / 1ps

// channel   dir   handshake                          tdata
// s_axis    in    i_s_axis_tvalid / o_s_axis_tready  link parameters, one link per beat
// m_axis    out   o_m_axis_tvalid / i_m_axis_tready  eleven transform entries per beat
//
// One beat in and one beat out per cycle, sustained while the output is not stalled.
// Each beat passes one CORDIC cell per stage for both angles, then
// rounding, products and the output register.
// Reset clears only the valid bits and the count of beats in flight.
// An output stall freezes the whole cell chain; the input skid register takes one more beat.
module dh_link_transform #(
    parameter int ANGLE_BITS  = dhlt_pkg::ANGLE_BITS_DEF,
    parameter int LENGTH_BITS = dhlt_pkg::LENGTH_BITS_DEF,
    parameter int TRIG_STAGES = dhlt_pkg::TRIG_STAGES_DEF,
    localparam int IN_BITS    = 2 * LENGTH_BITS + 2 * ANGLE_BITS,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = 128 + 3 * LENGTH_BITS,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // link_length, link_offset, twist_angle, joint_angle
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // m00_cos_theta, m01_neg_sin_theta, m03_translation_x, m10_st_ca, m11_ct_ca,
    // m12_neg_sin_alpha, m13_translation_y, m20_st_sa, m21_ct_sa, m22_cos_alpha,
    // m23_translation_z
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int CNT_W = $clog2(TRIG_STAGES + 5);

    logic                   r_skid_valid;
    logic [IN_BITS-1:0]     r_skid_data;
    logic                   w_in_acc;
    logic                   w_out_acc;
    logic                   w_en;
    logic                   w_head_valid;
    logic [IN_BITS-1:0]     w_head;
    logic [31:0]            w_z32_alpha;
    logic [31:0]            w_z32_theta;

    logic                   w_valid [TRIG_STAGES+1];
    dhlt_pkg::t_lane        w_alpha [TRIG_STAGES+1];
    dhlt_pkg::t_lane        w_theta [TRIG_STAGES+1];
    logic [LENGTH_BITS-1:0] w_len_a [TRIG_STAGES+1];
    logic [LENGTH_BITS-1:0] w_len_d [TRIG_STAGES+1];

    logic [15:0]            w_m00, w_m01, w_m10, w_m11, w_m12, w_m20, w_m21, w_m22;
    logic [LENGTH_BITS-1:0] w_m03, w_m13, w_m23;

    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_en      = !o_m_axis_tvalid || i_m_axis_tready;

    assign o_s_axis_tready = !r_skid_valid;

    // the skid beat always goes first; a fresh beat only enters with the skid empty
    assign w_head_valid = r_skid_valid || w_in_acc;
    assign w_head       = r_skid_valid ? r_skid_data : i_s_axis_tdata[IN_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_en) begin
            r_skid_data <= i_s_axis_tdata[IN_BITS-1:0];
        end
    end

    assign w_z32_alpha = 32'(w_head[2*LENGTH_BITS +: ANGLE_BITS]) << (32 - ANGLE_BITS);
    assign w_z32_theta = 32'(w_head[2*LENGTH_BITS+ANGLE_BITS +: ANGLE_BITS]) << (32 - ANGLE_BITS);

    assign w_valid[0] = w_head_valid;
    assign w_alpha[0] = dhlt_pkg::start_lane(w_z32_alpha);
    assign w_theta[0] = dhlt_pkg::start_lane(w_z32_theta);
    assign w_len_a[0] = w_head[0 +: LENGTH_BITS];
    assign w_len_d[0] = w_head[LENGTH_BITS +: LENGTH_BITS];

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
        dhlt_cell #(
            .STAGE       (g),
            .LENGTH_BITS (LENGTH_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_alpha (w_alpha[g]),
            .i_theta (w_theta[g]),
            .i_len_a (w_len_a[g]),
            .i_len_d (w_len_d[g]),
            .o_valid (w_valid[g+1]),
            .o_alpha (w_alpha[g+1]),
            .o_theta (w_theta[g+1]),
            .o_len_a (w_len_a[g+1]),
            .o_len_d (w_len_d[g+1])
        );
    end

    dhlt_fin #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[TRIG_STAGES]),
        .i_alpha (w_alpha[TRIG_STAGES]),
        .i_theta (w_theta[TRIG_STAGES]),
        .i_len_a (w_len_a[TRIG_STAGES]),
        .i_len_d (w_len_d[TRIG_STAGES]),
        .o_valid (o_m_axis_tvalid),
        .o_m00   (w_m00),
        .o_m01   (w_m01),
        .o_m03   (w_m03),
        .o_m10   (w_m10),
        .o_m11   (w_m11),
        .o_m12   (w_m12),
        .o_m13   (w_m13),
        .o_m20   (w_m20),
        .o_m21   (w_m21),
        .o_m22   (w_m22),
        .o_m23   (w_m23)
    );

    assign o_m_axis_tdata = OUT_W'({w_m23, w_m22, w_m21, w_m20, w_m13, w_m12, w_m11, w_m10,
                                    w_m03, w_m01, w_m00});

    // beats in flight, for the checks below
    assign n_cnt = r_cnt + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TRIG_STAGES + 4))
        else $error("more beats in flight than the chain can hold");

    a_out_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_cnt != '0)
        else $error("output beat with no accepted input behind it");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(!w_en))
        else $error("skid register filled while the chain was advancing");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_en) |=> (w_valid[1] && !r_skid_valid))
        else $error("skid beat not handed to the first cell");

endmodule

### bench/tb_dh_link_transform.sv
`timescale 1ns / 1ps

module tb_dh_link_transform;

    localparam int LEN_W       = dhlt_pkg::LENGTH_BITS_DEF;
    localparam int ANG_W       = dhlt_pkg::ANGLE_BITS_DEF;
    localparam int TRIG_W      = dhlt_pkg::TRIG_W;
    localparam int STAGES      = (dhlt_pkg::TRIG_STAGES_DEF < dhlt_pkg::ATAN_N) ?
                                 dhlt_pkg::TRIG_STAGES_DEF : dhlt_pkg::ATAN_N;
    localparam int LATENCY     = dhlt_pkg::TRIG_STAGES_DEF + 3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 240;

    // link parameters, link_length in the lowest bits
    typedef struct packed {
        logic [ANG_W-1:0]        joint_angle;
        logic [ANG_W-1:0]        twist_angle;
        logic signed [LEN_W-1:0] link_offset;
        logic signed [LEN_W-1:0] link_length;
    } link_t;

    // transform entries, m00_cos_theta in the lowest bits
    typedef struct packed {
        logic signed [LEN_W-1:0]  m23_translation_z;
        logic signed [TRIG_W-1:0] m22_cos_alpha;
        logic signed [TRIG_W-1:0] m21_ct_sa;
        logic signed [TRIG_W-1:0] m20_st_sa;
        logic signed [LEN_W-1:0]  m13_translation_y;
        logic signed [TRIG_W-1:0] m12_neg_sin_alpha;
        logic signed [TRIG_W-1:0] m11_ct_ca;
        logic signed [TRIG_W-1:0] m10_st_ca;
        logic signed [LEN_W-1:0]  m03_translation_x;
        logic signed [TRIG_W-1:0] m01_neg_sin_theta;
        logic signed [TRIG_W-1:0] m00_cos_theta;
    } xform_t;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_s_axis_tvalid = 1'b0;
    logic   o_s_axis_tready;
    // link_length, link_offset, twist_angle, joint_angle
    link_t  i_s_axis_tdata = '0;
    logic   o_m_axis_tvalid;
    logic   i_m_axis_tready = 1'b0;
    // m00_cos_theta, m01_neg_sin_theta, m03_translation_x, m10_st_ca, m11_ct_ca,
    // m12_neg_sin_alpha, m13_translation_y, m20_st_sa, m21_ct_sa, m22_cos_alpha,
    // m23_translation_z
    logic [$bits(xform_t)-1:0] o_m_axis_tdata;

    xform_t xform_due_q[$];
    int     fail_cnt = 0;
    bit     idle_on = 1'b1;
    int     rx_hold_req = 0;

    dh_link_transform dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint mul_q14(input longint p, input longint q);
        return (p * q + 64'sd8192) >>> 14;
    endfunction

    // CORDIC sine and cosine in Q2.14 after folding to the nearest quadrant
    function automatic void trig_q14(input logic [ANG_W-1:0] ang,
                                     output longint c, output longint s);
        logic [31:0]     z32;
        logic [31:0]     zsum;
        dhlt_pkg::t_quad quad;
        longint          x, y, z, dx, dy, t;
        z32  = 32'(ang) << (32 - ANG_W);
        zsum = z32 + 32'h2000_0000;
        quad = dhlt_pkg::t_quad'(zsum[31:30]);
        z    = longint'($signed(z32 - {zsum[31:30], 30'd0}));
        x    = longint'(dhlt_pkg::X_INIT);
        y    = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(dhlt_pkg::ATAN_TURN[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(dhlt_pkg::ATAN_TURN[i]);
            end
        end
        c = clamp_to((x + 64'sd32768) >>> 16, -longint'(dhlt_pkg::ONE_Q14),
                     longint'(dhlt_pkg::ONE_Q14));
        s = clamp_to((y + 64'sd32768) >>> 16, -longint'(dhlt_pkg::ONE_Q14),
                     longint'(dhlt_pkg::ONE_Q14));
        case (quad)
            dhlt_pkg::QUAD_1: begin
                t = c;
                c = -s;
                s = t;
            end
            dhlt_pkg::QUAD_2: begin
                c = -c;
                s = -s;
            end
            dhlt_pkg::QUAD_3: begin
                t = c;
                c = s;
                s = -t;
            end
            default: ;
        endcase
    endfunction

    function automatic xform_t predict_link_xform(input link_t lk);
        longint ca, sa, ct, st, d, lmax, lmin;
        xform_t xf;
        lmax = longint'((64'd1 << (LEN_W - 1)) - 1);
        lmin = -lmax - 1;
        d    = longint'(lk.link_offset);
        trig_q14(lk.twist_angle, ca, sa);
        trig_q14(lk.joint_angle, ct, st);
        xf.m00_cos_theta     = TRIG_W'(ct);
        xf.m01_neg_sin_theta = TRIG_W'(-st);
        xf.m03_translation_x = lk.link_length;
        xf.m10_st_ca         = TRIG_W'(mul_q14(st, ca));
        xf.m11_ct_ca         = TRIG_W'(mul_q14(ct, ca));
        xf.m12_neg_sin_alpha = TRIG_W'(-sa);
        xf.m13_translation_y = LEN_W'(clamp_to(mul_q14(-sa, d), lmin, lmax));
        xf.m20_st_sa         = TRIG_W'(mul_q14(st, sa));
        xf.m21_ct_sa         = TRIG_W'(mul_q14(ct, sa));
        xf.m22_cos_alpha     = TRIG_W'(ca);
        xf.m23_translation_z = LEN_W'(clamp_to(mul_q14(ca, d), lmin, lmax));
        return xf;
    endfunction

    function automatic link_t mk_link(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] d,
                                      input logic [ANG_W-1:0] alpha,
                                      input logic [ANG_W-1:0] theta);
        link_t lk;
        lk.link_length = a;
        lk.link_offset = d;
        lk.twist_angle = alpha;
        lk.joint_angle = theta;
        return lk;
    endfunction

    function automatic logic [LEN_W-1:0] random_len();
        logic [LEN_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = {1'b0, {(LEN_W-1){1'b1}}};
            1:       v = {1'b1, {(LEN_W-1){1'b0}}};
            2:       v = LEN_W'($urandom_range(0, 1 << 18));
            3:       v = -LEN_W'($urandom_range(0, 1 << 18));
            default: v = LEN_W'($urandom);
        endcase
        return v;
    endfunction

    // bias toward quadrant folds and octant edges
    function automatic logic [ANG_W-1:0] random_angle();
        logic [ANG_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = ANG_W'(($urandom_range(0, 7) << (ANG_W - 3)) + $urandom_range(0, 4) - 2);
            1:       v = ANG_W'($urandom_range(0, 3) << (ANG_W - 2));
            default: v = ANG_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic link_t random_link();
        return mk_link(random_len(), random_len(), random_angle(), random_angle());
    endfunction

    // hold the beat until taken, then queue its transform
    task automatic send_link(input link_t lk);
        logic rdy;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= lk;
        do begin
            @(negedge i_clk);
            rdy = o_s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        xform_due_q.push_back(predict_link_xform(lk));
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (xform_due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        link_t lk[$];
        lk.push_back(mk_link(32'sd0, 32'sd0, 16'h0000, 16'h0000));
        lk.push_back(mk_link(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h4000, 16'h4000));
        // offset at the negative end with a unit factor of -1: translations clamp
        lk.push_back(mk_link(32'sh8000_0000, 32'sh8000_0000, 16'h8000, 16'h8000));
        lk.push_back(mk_link(32'sh8000_0000, 32'sh8000_0000, 16'h4000, 16'hC000));
        // unit factor of +1 keeps the product exactly in range
        lk.push_back(mk_link(32'sd1, 32'sh8000_0000, 16'h0000, 16'h2000));
        lk.push_back(mk_link(-32'sd1, 32'sh8000_0000, 16'hC000, 16'h6000));
        lk.push_back(mk_link(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h8000, 16'hA000));
        lk.push_back(mk_link(-32'sd1, -32'sd1, 16'hC000, 16'hFFFF));
        lk.push_back(mk_link(32'sd1, 32'sd1, 16'hFFFF, 16'h0001));
        // octant edges, where the quadrant fold flips
        lk.push_back(mk_link(32'sh0001_0000, 32'sh0002_0000, 16'h2000, 16'h1FFF));
        lk.push_back(mk_link(-32'sh0001_0000, 32'sh0003_8000, 16'h6000, 16'h5FFF));
        lk.push_back(mk_link(32'sh1234_5678, -32'sh0002_0000, 16'hA000, 16'h9FFF));
        lk.push_back(mk_link(32'shEDCB_A987, 32'sh5555_5555, 16'hE000, 16'hDFFF));
        lk.push_back(mk_link(32'sh5555_5555, 32'shAAAA_AAAA, 16'h1FFF, 16'hE000));
        lk.push_back(mk_link(32'shAAAA_AAAA, 32'sh0000_FFFF, 16'h5555, 16'hAAAA));
        lk.push_back(mk_link(32'sh0000_FFFF, 32'shFFFF_0000, 16'hAAAA, 16'h5555));
        foreach (lk[k]) send_link(lk[k]);
        wait_drained();
    endtask

    task automatic test_random_stream(input int n);
        for (int k = 0; k < n; k++) begin
            // every third stretch runs without gaps
            if (k % 60 == 0) idle_on = ((k / 60) % 3 != 2);
            send_link(random_link());
            sender_gap();
        end
    endtask

    task automatic test_output_backpressure(input int n);
        idle_on     = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        for (int k = 0; k < n; k++) send_link(random_link());
    endtask

    task automatic test_drain_pause(input int n);
        idle_on = 1'b1;
        for (int k = 0; k < n; k++) begin
            send_link(random_link());
            sender_gap();
            if (k % 30 == 29) wait_drained();
        end
    endtask

    task automatic test_full_rate(input int n);
        idle_on = 1'b0;
        for (int k = 0; k < n; k++) send_link(random_link());
    endtask

    initial begin : result_check
        logic   fire;
        xform_t got;
        xform_t want;
        int     stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            fire = o_m_axis_tvalid && i_m_axis_tready;
            got  = o_m_axis_tdata;
            @(posedge i_clk);
            if (fire) begin
                if (xform_due_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("transform beat with none due: %h", got);
                end else begin
                    want = xform_due_q.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("exp m00 %0d m01 %0d m03 %0d m10 %0d m11 %0d m12 %0d",
                                     want.m00_cos_theta, want.m01_neg_sin_theta,
                                     want.m03_translation_x, want.m10_st_ca, want.m11_ct_ca,
                                     want.m12_neg_sin_alpha);
                            $display("    m13 %0d m20 %0d m21 %0d m22 %0d m23 %0d",
                                     want.m13_translation_y, want.m20_st_sa, want.m21_ct_sa,
                                     want.m22_cos_alpha, want.m23_translation_z);
                            $display("got m00 %0d m01 %0d m03 %0d m10 %0d m11 %0d m12 %0d",
                                     got.m00_cos_theta, got.m01_neg_sin_theta,
                                     got.m03_translation_x, got.m10_st_ca, got.m11_ct_ca,
                                     got.m12_neg_sin_alpha);
                            $display("    m13 %0d m20 %0d m21 %0d m22 %0d m23 %0d",
                                     got.m13_translation_y, got.m20_st_sa, got.m21_ct_sa,
                                     got.m22_cos_alpha, got.m23_translation_z);
                        end
                    end
                end
            end
            // long hold-off first, then random stall bursts
            if (rx_hold_req > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_hold_req--;
            end else if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int   quiet;
        logic moved;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge i_clk);
            moved = (i_s_axis_tvalid && o_s_axis_tready) ||
                    (o_m_axis_tvalid && i_m_axis_tready);
            @(posedge i_clk);
            quiet = moved ? 0 : quiet + 1;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : run_tests
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_stream(540);
        test_output_backpressure(60);
        test_drain_pause(90);
        test_full_rate(450);
        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (fail_cnt == 0 && xform_due_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dhlt_pkg.sv
rtl/dhlt_cell.sv
rtl/dhlt_fin.sv
rtl/dh_link_transform.sv
bench/tb_dh_link_transform.sv
